// ----- rtl/core/cpu8_pkg.sv -----
`default_nettype none

package cpu8_pkg;

   // Status register bit positions.
   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_B = 4;
   localparam int FLAG_U = 5;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   localparam logic [7:0] ACC_RESET   = 8'h00;
   localparam logic [7:0] INDEX_RESET = 8'h00;
   localparam logic [7:0] SP_RESET    = 8'hFD;
   localparam logic [7:0] FLAGS_RESET = 8'h24;

   // Request side: tuser carries the operation kind, tdata the rest.
   localparam int KIND_W     = 6;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 56;

   typedef enum logic [KIND_W-1:0] {
      K_LDA    = 6'd0,
      K_LDX    = 6'd1,
      K_LDY    = 6'd2,
      K_ADC    = 6'd3,
      K_SBC    = 6'd4,
      K_AND    = 6'd5,
      K_ORA    = 6'd6,
      K_EOR    = 6'd7,
      K_CMP    = 6'd8,
      K_CPX    = 6'd9,
      K_CPY    = 6'd10,
      K_BIT    = 6'd11,
      K_ASL    = 6'd12,
      K_LSR    = 6'd13,
      K_ROL    = 6'd14,
      K_ROR    = 6'd15,
      K_INC    = 6'd16,
      K_DEC    = 6'd17,
      K_INX    = 6'd18,
      K_INY    = 6'd19,
      K_DEX    = 6'd20,
      K_DEY    = 6'd21,
      K_TAX    = 6'd22,
      K_TAY    = 6'd23,
      K_TXA    = 6'd24,
      K_TYA    = 6'd25,
      K_TSX    = 6'd26,
      K_TXS    = 6'd27,
      K_CLC    = 6'd28,
      K_SEC    = 6'd29,
      K_CLD    = 6'd30,
      K_SED    = 6'd31,
      K_CLI    = 6'd32,
      K_SEI    = 6'd33,
      K_CLV    = 6'd34,
      K_PLP    = 6'd35,
      K_PHP    = 6'd36,
      K_PHA    = 6'd37,
      K_PLA    = 6'd38,
      K_BRANCH = 6'd39,
      K_PUSH   = 6'd40,
      K_PULL   = 6'd41
   } kind_type;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] sp;
      logic [7:0] flags;
   } arch_state_type;

   typedef struct packed {
      logic       branch_taken;
      logic [8:0] stack_address;
      logic [7:0] status;
      logic [7:0] index_y;
      logic [7:0] index_x;
      logic [7:0] acc;
      logic [7:0] write_byte;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/core/cpu8_alu.sv -----
`default_nettype none

module cpu8_alu
   import cpu8_pkg::*;
(
   input  wire logic [KIND_W-1:0] kind,
   input  wire logic [7:0]        operand,
   input  wire logic              on_accumulator,
   input  wire logic [2:0]        condition,
   input  wire arch_state_type    cur_state,
   output arch_state_type         next_state,
   output result_type             result
);

   function automatic logic [7:0] with_zn(input logic [7:0] flags, input logic [7:0] v);
      logic [7:0] f;
      f         = flags;
      f[FLAG_Z] = (v == 8'h00);
      f[FLAG_N] = v[7];
      return f;
   endfunction

   kind_type    op;
   logic [7:0]  acc_n, x_n, y_n, sp_n, fl_n, wb;
   logic [7:0]  addr_ptr;
   logic        taken;
   logic [7:0]  add_arg;
   logic [8:0]  sum;
   logic [7:0]  cmp_reg;
   logic [8:0]  diff;
   logic [7:0]  shift_src, shift_res;
   logic        shift_carry;
   logic        cond_flag;

   assign op = kind_type'(kind);

   // Shared adder for ADC and SBC; SBC adds the inverted operand.
   assign add_arg = (op == K_SBC) ? ~operand : operand;
   assign sum     = {1'b0, cur_state.acc} + {1'b0, add_arg}
                  + {8'h00, cur_state.flags[FLAG_C]};

   // Shared comparator; the borrow bit of the difference is the inverted carry.
   always_comb begin
      case (op)
         K_CPX:   cmp_reg = cur_state.x;
         K_CPY:   cmp_reg = cur_state.y;
         default: cmp_reg = cur_state.acc;
      endcase
   end
   assign diff = {1'b0, cmp_reg} - {1'b0, operand};

   assign shift_src = on_accumulator ? cur_state.acc : operand;
   always_comb begin
      case (op)
         K_ASL: begin
            shift_res   = {shift_src[6:0], 1'b0};
            shift_carry = shift_src[7];
         end
         K_ROL: begin
            shift_res   = {shift_src[6:0], cur_state.flags[FLAG_C]};
            shift_carry = shift_src[7];
         end
         K_LSR: begin
            shift_res   = {1'b0, shift_src[7:1]};
            shift_carry = shift_src[0];
         end
         default: begin
            shift_res   = {cur_state.flags[FLAG_C], shift_src[7:1]};
            shift_carry = shift_src[0];
         end
      endcase
   end

   always_comb begin
      case (condition[2:1])
         2'd0:    cond_flag = cur_state.flags[FLAG_N];
         2'd1:    cond_flag = cur_state.flags[FLAG_V];
         2'd2:    cond_flag = cur_state.flags[FLAG_C];
         default: cond_flag = cur_state.flags[FLAG_Z];
      endcase
   end

   always_comb begin
      acc_n    = cur_state.acc;
      x_n      = cur_state.x;
      y_n      = cur_state.y;
      sp_n     = cur_state.sp;
      fl_n     = cur_state.flags;
      wb       = 8'h00;
      addr_ptr = cur_state.sp;
      taken    = 1'b0;
      case (op)
         K_LDA: begin
            acc_n = operand;
            fl_n  = with_zn(fl_n, operand);
         end
         K_LDX: begin
            x_n  = operand;
            fl_n = with_zn(fl_n, operand);
         end
         K_LDY: begin
            y_n  = operand;
            fl_n = with_zn(fl_n, operand);
         end
         K_ADC, K_SBC: begin
            acc_n        = sum[7:0];
            fl_n[FLAG_C] = sum[8];
            fl_n[FLAG_V] = ~(cur_state.acc[7] ^ add_arg[7]) & (cur_state.acc[7] ^ sum[7]);
            fl_n         = with_zn(fl_n, sum[7:0]);
         end
         K_AND: begin
            acc_n = cur_state.acc & operand;
            fl_n  = with_zn(fl_n, cur_state.acc & operand);
         end
         K_ORA: begin
            acc_n = cur_state.acc | operand;
            fl_n  = with_zn(fl_n, cur_state.acc | operand);
         end
         K_EOR: begin
            acc_n = cur_state.acc ^ operand;
            fl_n  = with_zn(fl_n, cur_state.acc ^ operand);
         end
         K_CMP, K_CPX, K_CPY: begin
            fl_n[FLAG_C] = ~diff[8];
            fl_n         = with_zn(fl_n, diff[7:0]);
         end
         K_BIT: begin
            fl_n[FLAG_Z] = ((cur_state.acc & operand) == 8'h00);
            fl_n[FLAG_N] = operand[7];
            fl_n[FLAG_V] = operand[6];
         end
         K_ASL, K_LSR, K_ROL, K_ROR: begin
            fl_n[FLAG_C] = shift_carry;
            fl_n         = with_zn(fl_n, shift_res);
            if (on_accumulator) begin
               acc_n = shift_res;
            end else begin
               wb = shift_res;
            end
         end
         K_INC: begin
            wb   = operand + 8'd1;
            fl_n = with_zn(fl_n, operand + 8'd1);
         end
         K_DEC: begin
            wb   = operand - 8'd1;
            fl_n = with_zn(fl_n, operand - 8'd1);
         end
         K_INX: begin
            x_n  = cur_state.x + 8'd1;
            fl_n = with_zn(fl_n, cur_state.x + 8'd1);
         end
         K_INY: begin
            y_n  = cur_state.y + 8'd1;
            fl_n = with_zn(fl_n, cur_state.y + 8'd1);
         end
         K_DEX: begin
            x_n  = cur_state.x - 8'd1;
            fl_n = with_zn(fl_n, cur_state.x - 8'd1);
         end
         K_DEY: begin
            y_n  = cur_state.y - 8'd1;
            fl_n = with_zn(fl_n, cur_state.y - 8'd1);
         end
         K_TAX: begin
            x_n  = cur_state.acc;
            fl_n = with_zn(fl_n, cur_state.acc);
         end
         K_TAY: begin
            y_n  = cur_state.acc;
            fl_n = with_zn(fl_n, cur_state.acc);
         end
         K_TXA: begin
            acc_n = cur_state.x;
            fl_n  = with_zn(fl_n, cur_state.x);
         end
         K_TYA: begin
            acc_n = cur_state.y;
            fl_n  = with_zn(fl_n, cur_state.y);
         end
         K_TSX: begin
            x_n  = cur_state.sp;
            fl_n = with_zn(fl_n, cur_state.sp);
         end
         K_TXS: begin
            sp_n     = cur_state.x;
            addr_ptr = cur_state.x;
         end
         K_CLC: fl_n[FLAG_C] = 1'b0;
         K_SEC: fl_n[FLAG_C] = 1'b1;
         K_CLD: fl_n[FLAG_D] = 1'b0;
         K_SED: fl_n[FLAG_D] = 1'b1;
         K_CLI: fl_n[FLAG_I] = 1'b0;
         K_SEI: fl_n[FLAG_I] = 1'b1;
         K_CLV: fl_n[FLAG_V] = 1'b0;
         // Pulls report the pointer after its increment.
         K_PLP: begin
            sp_n     = cur_state.sp + 8'd1;
            addr_ptr = cur_state.sp + 8'd1;
            fl_n     = operand;
         end
         K_PLA: begin
            sp_n     = cur_state.sp + 8'd1;
            addr_ptr = cur_state.sp + 8'd1;
            acc_n    = operand;
            fl_n     = with_zn(fl_n, operand);
         end
         K_PULL: begin
            sp_n     = cur_state.sp + 8'd1;
            addr_ptr = cur_state.sp + 8'd1;
         end
         // Pushes report the pointer before its decrement.
         K_PHP: begin
            wb           = cur_state.flags;
            wb[FLAG_B]   = 1'b1;
            wb[FLAG_U]   = 1'b1;
            sp_n         = cur_state.sp - 8'd1;
         end
         K_PHA: begin
            wb   = cur_state.acc;
            sp_n = cur_state.sp - 8'd1;
         end
         K_PUSH: begin
            wb   = operand;
            sp_n = cur_state.sp - 8'd1;
         end
         K_BRANCH: taken = condition[0] ? cond_flag : ~cond_flag;
         default: begin
         end
      endcase
      fl_n[FLAG_B] = 1'b0;
      fl_n[FLAG_U] = 1'b1;
   end

   always_comb begin
      next_state.acc   = acc_n;
      next_state.x     = x_n;
      next_state.y     = y_n;
      next_state.sp    = sp_n;
      next_state.flags = fl_n;

      result.write_byte    = wb;
      result.acc           = acc_n;
      result.index_x       = x_n;
      result.index_y       = y_n;
      result.status        = fl_n;
      result.stack_address = {1'b1, addr_ptr};
      result.branch_taken  = taken;
   end

endmodule

`default_nettype wire

// ----- rtl/core/cpu8_register_alu_execute_unit_top.sv -----
// Response: an accepted transaction moves from the request register into the result
// register, which drives rsp_tvalid, once that register is empty or rsp_tready is high.
// Throughput: one transaction per cycle while rsp_tready stays high; the request register
// and the result register form a two-stage pipeline, and the combinational ALU updates A,
// X, Y, the stack pointer and status as an item moves into the result register.
// Reset: synchronous; A, X, Y clear to zero, the stack pointer to 0xFD, status to 0x24.
`default_nettype none

module cpu8_register_alu_execute_unit_top
   import cpu8_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // Fields from bit 0 up: operand[7:0], on_accumulator[8], condition[11:9], zero fill.
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0 up: kind[5:0].
   input  wire logic [KIND_W-1:0]     req_tuser,

   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // Fields from bit 0 up: write_byte[7:0], acc[15:8], index_x[23:16], index_y[31:24],
   // status[39:32], stack_address[48:40], branch_taken[49], zero fill.
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   logic              in_valid_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [7:0]        operand_ff;
   logic              on_acc_ff;
   logic [2:0]        cond_ff;

   arch_state_type    state_ff;
   arch_state_type    state_in;
   result_type        result_in;
   result_type        rsp_ff;
   logic              rsp_valid_ff;
   logic              exec_fire;
   logic              req_fire;

   assign exec_fire  = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || exec_fire;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff    <= req_tuser;
         operand_ff <= req_tdata[7:0];
         on_acc_ff  <= req_tdata[8];
         cond_ff    <= req_tdata[11:9];
      end
   end

   cpu8_alu u_alu (
      .kind           (kind_ff),
      .operand        (operand_ff),
      .on_accumulator (on_acc_ff),
      .condition      (cond_ff),
      .cur_state      (state_ff),
      .next_state     (state_in),
      .result         (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.acc   <= ACC_RESET;
         state_ff.x     <= INDEX_RESET;
         state_ff.y     <= INDEX_RESET;
         state_ff.sp    <= SP_RESET;
         state_ff.flags <= FLAGS_RESET;
      end else if (exec_fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(result_type)){1'b0}}, rsp_ff};

   // A push moves the pointer down by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      exec_fire && (kind_ff == K_PHA || kind_ff == K_PHP || kind_ff == K_PUSH)
      |=> state_ff.sp == $past(state_ff.sp) - 8'd1)
      else $error("stack pointer not decremented by push");

   // Architectural registers change only when an item executes.
   assert property (@(posedge clock) disable iff (reset)
      !exec_fire |=> $stable(state_ff))
      else $error("register state changed without an executing item");

   // Every executed item leaves a result behind.
   assert property (@(posedge clock) disable iff (reset)
      exec_fire |=> rsp_valid_ff)
      else $error("executed item produced no result");

   // The stored status always has bit 5 set and B clear.
   assert property (@(posedge clock) disable iff (reset)
      exec_fire |=> state_ff.flags[FLAG_U] && !state_ff.flags[FLAG_B])
      else $error("status register holds B set or bit 5 clear");

endmodule

`default_nettype wire

// ----- sim/cpu8_execute_checker.sv -----
`timescale 1ns / 100ps

module cpu8_execute_checker
   import cpu8_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   // Fields from bit 0 up: operand[7:0], on_accumulator[8], condition[11:9], zero fill.
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0 up: kind[5:0].
   input  wire logic [KIND_W-1:0]     req_tuser,

   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // Fields from bit 0 up: write_byte, acc, index_x, index_y, status,
   // stack_address, branch_taken, zero fill.
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,

   output int                         outstanding,
   output int                         error_count
);

   logic [7:0] acc_q;
   logic [7:0] x_q;
   logic [7:0] y_q;
   logic [7:0] sp_q;
   logic [7:0] flags_q;

   result_type expected_results[$];
   int         issued;
   int         retired;

   assign outstanding = issued - retired;

   function automatic logic [7:0] with_zn(input logic [7:0] p, input logic [7:0] v);
      logic [7:0] q;
      begin
         q = p;
         q[FLAG_Z] = (v == 8'h00);
         q[FLAG_N] = v[7];
         return q;
      end
   endfunction

   // Architectural update of one operation; returns the result the block must report.
   task automatic execute_op(input logic [KIND_W-1:0] kind, input logic [7:0] opnd,
                             input logic on_acc, input logic [2:0] cond,
                             output result_type r);
      logic [7:0] p;
      logic [7:0] wb;
      logic [7:0] v;
      logic [7:0] res;
      logic [8:0] sum;
      logic [8:0] saddr;
      logic       taken;
      logic       cin;
      logic       flag_bit;
      begin
         p     = flags_q;
         wb    = 8'h00;
         taken = 1'b0;
         saddr = {1'b1, sp_q};
         case (kind)
            K_LDA: begin
               acc_q = opnd;
               p = with_zn(p, opnd);
            end
            K_LDX: begin
               x_q = opnd;
               p = with_zn(p, opnd);
            end
            K_LDY: begin
               y_q = opnd;
               p = with_zn(p, opnd);
            end
            K_ADC, K_SBC: begin
               // Subtraction is addition of the complement; decimal mode is ignored.
               v   = (kind == K_SBC) ? ~opnd : opnd;
               sum = {1'b0, acc_q} + {1'b0, v} + {8'h00, p[FLAG_C]};
               res = sum[7:0];
               p[FLAG_C] = sum[8];
               p[FLAG_V] = ~(acc_q[7] ^ v[7]) & (acc_q[7] ^ res[7]);
               acc_q = res;
               p = with_zn(p, res);
            end
            K_AND: begin
               acc_q = acc_q & opnd;
               p = with_zn(p, acc_q);
            end
            K_ORA: begin
               acc_q = acc_q | opnd;
               p = with_zn(p, acc_q);
            end
            K_EOR: begin
               acc_q = acc_q ^ opnd;
               p = with_zn(p, acc_q);
            end
            K_CMP, K_CPX, K_CPY: begin
               v = (kind == K_CMP) ? acc_q : (kind == K_CPX) ? x_q : y_q;
               p[FLAG_C] = (v >= opnd);
               p = with_zn(p, v - opnd);
            end
            K_BIT: begin
               p[FLAG_Z] = ((acc_q & opnd) == 8'h00);
               p[FLAG_N] = opnd[7];
               p[FLAG_V] = opnd[6];
            end
            K_ASL, K_LSR, K_ROL, K_ROR: begin
               v   = on_acc ? acc_q : opnd;
               cin = p[FLAG_C];
               case (kind)
                  K_ASL: begin
                     p[FLAG_C] = v[7];
                     res = {v[6:0], 1'b0};
                  end
                  K_LSR: begin
                     p[FLAG_C] = v[0];
                     res = {1'b0, v[7:1]};
                  end
                  K_ROL: begin
                     p[FLAG_C] = v[7];
                     res = {v[6:0], cin};
                  end
                  default: begin
                     p[FLAG_C] = v[0];
                     res = {cin, v[7:1]};
                  end
               endcase
               p = with_zn(p, res);
               if (on_acc) begin
                  acc_q = res;
               end else begin
                  wb = res;
               end
            end
            K_INC: begin
               wb = opnd + 8'd1;
               p = with_zn(p, wb);
            end
            K_DEC: begin
               wb = opnd - 8'd1;
               p = with_zn(p, wb);
            end
            K_INX: begin
               x_q = x_q + 8'd1;
               p = with_zn(p, x_q);
            end
            K_INY: begin
               y_q = y_q + 8'd1;
               p = with_zn(p, y_q);
            end
            K_DEX: begin
               x_q = x_q - 8'd1;
               p = with_zn(p, x_q);
            end
            K_DEY: begin
               y_q = y_q - 8'd1;
               p = with_zn(p, y_q);
            end
            K_TAX: begin
               x_q = acc_q;
               p = with_zn(p, x_q);
            end
            K_TAY: begin
               y_q = acc_q;
               p = with_zn(p, y_q);
            end
            K_TXA: begin
               acc_q = x_q;
               p = with_zn(p, acc_q);
            end
            K_TYA: begin
               acc_q = y_q;
               p = with_zn(p, acc_q);
            end
            K_TSX: begin
               x_q = sp_q;
               p = with_zn(p, x_q);
            end
            K_TXS: begin
               sp_q  = x_q;
               saddr = {1'b1, sp_q};
            end
            K_CLC: p[FLAG_C] = 1'b0;
            K_SEC: p[FLAG_C] = 1'b1;
            K_CLD: p[FLAG_D] = 1'b0;
            K_SED: p[FLAG_D] = 1'b1;
            K_CLI: p[FLAG_I] = 1'b0;
            K_SEI: p[FLAG_I] = 1'b1;
            K_CLV: p[FLAG_V] = 1'b0;
            K_PLP, K_PLA, K_PULL: begin
               // A pull reports the pointer after its increment.
               sp_q  = sp_q + 8'd1;
               saddr = {1'b1, sp_q};
               if (kind == K_PLP) begin
                  p = opnd;
               end else if (kind == K_PLA) begin
                  acc_q = opnd;
                  p = with_zn(p, opnd);
               end
            end
            K_PHP, K_PHA, K_PUSH: begin
               // A push reports the pointer before its decrement.
               if (kind == K_PHP) begin
                  wb = p;
                  wb[FLAG_B] = 1'b1;
                  wb[FLAG_U] = 1'b1;
               end else if (kind == K_PHA) begin
                  wb = acc_q;
               end else begin
                  wb = opnd;
               end
               saddr = {1'b1, sp_q};
               sp_q  = sp_q - 8'd1;
            end
            K_BRANCH: begin
               case (cond[2:1])
                  2'd0:    flag_bit = p[FLAG_N];
                  2'd1:    flag_bit = p[FLAG_V];
                  2'd2:    flag_bit = p[FLAG_C];
                  default: flag_bit = p[FLAG_Z];
               endcase
               taken = cond[0] ? flag_bit : ~flag_bit;
            end
            default: ;
         endcase
         p[FLAG_B] = 1'b0;
         p[FLAG_U] = 1'b1;
         flags_q = p;

         r.write_byte    = wb;
         r.acc           = acc_q;
         r.index_x       = x_q;
         r.index_y       = y_q;
         r.status        = flags_q;
         r.stack_address = saddr;
         r.branch_taken  = taken;
      end
   endtask

   task automatic check_field(input string name, input logic [8:0] want,
                              input logic [8:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      result_type want;
      result_type got;
      if (reset) begin
         acc_q   = ACC_RESET;
         x_q     = INDEX_RESET;
         y_q     = INDEX_RESET;
         sp_q    = SP_RESET;
         flags_q = FLAGS_RESET;
         expected_results.delete();
         issued  <= 0;
         retired <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            execute_op(req_tuser, req_tdata[7:0], req_tdata[8], req_tdata[11:9], want);
            expected_results.push_back(want);
            issued <= issued + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result transaction, expected none, got 0x%0h",
                        $time, got);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               retired <= retired + 1;
               check_field("write_byte", want.write_byte, got.write_byte);
               check_field("acc", want.acc, got.acc);
               check_field("index_x", want.index_x, got.index_x);
               check_field("index_y", want.index_y, got.index_y);
               check_field("status", want.status, got.status);
               check_field("stack_address", want.stack_address, got.stack_address);
               check_field("branch_taken", want.branch_taken, got.branch_taken);
            end
         end
      end
   end

endmodule

// ----- sim/cpu8_register_alu_execute_unit_top_tb.sv -----
`timescale 1ns / 100ps

module cpu8_register_alu_execute_unit_top_tb;
   import cpu8_pkg::*;

   localparam int              RANDOM_OPS       = 395;
   localparam int              LONG_HOLD_CYCLES = 80;
   localparam logic [KIND_W-1:0] KIND_UNUSED_LOW  = 6'd42;
   localparam logic [KIND_W-1:0] KIND_UNUSED_HIGH = 6'd63;
   localparam logic [7:0]      CORNER_BYTES [4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int outstanding;
   int error_count;
   int hold_requests = 0;
   bit no_idle = 1'b0;

   cpu8_register_alu_execute_unit_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   cpu8_execute_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .outstanding (outstanding),
      .error_count (error_count)
   );

   always #1 clock = ~clock;

   function automatic int idle_cycles();
      return no_idle ? 0 : $urandom_range(0, 8);
   endfunction

   // Offers one transaction and returns right after the edge that accepts it.
   task automatic send_op(input logic [KIND_W-1:0] kind, input logic [7:0] opnd,
                          input logic on_acc, input logic [2:0] cond);
      int gap;
      begin
         gap = idle_cycles();
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tuser  <= kind;
         req_tdata  <= {4'b0000, cond, on_acc, opnd};
         do @(posedge clock); while (!req_tready);
      end
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic send_random();
      logic [KIND_W-1:0] kind;
      logic [7:0]        opnd;
      begin
         if ($urandom_range(0, 9) == 0) begin
            kind = KIND_W'($urandom_range(KIND_UNUSED_LOW, KIND_UNUSED_HIGH));
         end else begin
            kind = KIND_W'($urandom_range(K_LDA, K_PULL));
         end
         if ($urandom_range(0, 3) == 0) begin
            opnd = CORNER_BYTES[$urandom_range(0, 3)];
         end else begin
            opnd = 8'($urandom);
         end
         send_op(kind, opnd, 1'($urandom), 3'($urandom));
      end
   endtask

   // Receiver: random stalls, plus one long hold-off when the sender asks for it.
   initial begin : receiver
      int holds_done;
      int gap;
      holds_done = 0;
      while (reset) @(posedge clock);
      forever begin
         if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = idle_cycles();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every operation once, with corner operands and both shift targets.
      for (int k = K_LDA; k <= K_PULL; k++) begin
         send_op(KIND_W'(k), CORNER_BYTES[k % 4], k[0], 3'(k));
      end
      // Decimal mode set: addition must stay binary, with signed overflow.
      send_op(K_SED, 8'h00, 1'b0, 3'd0);
      send_op(K_LDA, 8'h7F, 1'b0, 3'd0);
      send_op(K_ADC, 8'h01, 1'b0, 3'd0);
      // Stack pointer wraps below zero on a push and above 0xFF on a pull.
      send_op(K_LDX, 8'h00, 1'b0, 3'd0);
      send_op(K_TXS, 8'h00, 1'b0, 3'd0);
      send_op(K_PHA, 8'h00, 1'b0, 3'd0);
      send_op(K_PULL, 8'hA5, 1'b0, 3'd0);
      send_op(K_PLP, 8'hFF, 1'b0, 3'd0);
      send_op(K_PHP, 8'h00, 1'b0, 3'd0);
      send_op(K_BRANCH, 8'h00, 1'b0, 3'd7);
      // BIT takes N and V from the operand even when the AND is zero.
      send_op(K_LDA, 8'h3F, 1'b0, 3'd0);
      send_op(K_BIT, 8'hC0, 1'b0, 3'd0);
      send_op(KIND_UNUSED_HIGH, 8'hFF, 1'b1, 3'd7);
      wait_for_results();

      for (int i = 0; i < RANDOM_OPS; i++) begin
         if (i == 150) begin
            hold_requests <= hold_requests + 1;
         end
         if (i == 200) begin
            no_idle <= 1'b1;
         end
         if (i == 260) begin
            no_idle <= 1'b0;
         end
         if (i == 300) begin
            wait_for_results();
         end
         send_random();
      end

      wait_for_results();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #1_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
